FILE: sv/rwtf_pkg.sv
// Shared types and constants of the raycast wall texel fetch block.
// No dependencies; imported by the texel store and the top level.
`timescale 1ns / 1ps

package rwtf_pkg;

   // Width of a texture size register and of texel coordinates.
   localparam int unsigned DIM_W = 7;

   localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
   localparam logic [31:0] MAGENTA = 32'h00FF00FF;
   localparam logic [31:0] HALF_MASK = 32'h007F7F7F;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_SHADE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      FACE_EAST  = 2'd0,
      FACE_WEST  = 2'd1,
      FACE_SOUTH = 2'd2,
      FACE_NORTH = 2'd3
   } face_type;

   typedef enum logic {
      REG_TEX_WIDTH  = 1'b0,
      REG_TEX_HEIGHT = 1'b1
   } reg_index_type;

   // Per-beat context that rides along the pipeline.
   typedef struct packed {
      kind_type         kind;
      face_type         lface;
      logic [11:0]      lidx;
      logic [31:0]      ltex;
      logic             side;
      face_type         face;
      logic             mirror;
      logic [DIM_W-1:0] tx;
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      logic [10:0]      ds;
      logic [10:0]      rw;
   } item_type;

   // Control from the pipeline to the texel store.
   typedef struct packed {
      logic     advance;
      logic     write;
      face_type write_face;
      face_type read_face;
   } store_ctl_type;

endpackage

FILE: sv/rwtf_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a payload lane.
// Stand-alone; instantiated by the top level.
`timescale 1ns / 1ps

module rwtf_div_pipe #(
   parameter int unsigned DW = 25,
   parameter int unsigned VW = 24,
   parameter int unsigned PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   input  logic [PW-1:0] in_payload,
   output logic          out_valid,
   output logic [DW-1:0] quotient,
   output logic [PW-1:0] out_payload
);

   logic [VW-1:0] rem_ff  [DW];
   logic [DW-1:0] work_ff [DW];
   logic [VW-1:0] dvs_ff  [DW];
   logic [PW-1:0] pay_ff  [DW];
   logic [DW-1:0] vld_ff;

   for (genvar k = 0; k < DW; k++) begin : g_stage
      logic [VW-1:0] rem_prev;
      logic [DW-1:0] work_prev;
      logic [VW-1:0] dvs_prev;
      logic [PW-1:0] pay_prev;
      logic          vld_prev;
      logic [VW:0]   trial;
      logic          fits;
      logic [VW-1:0] rem_in;
      logic [DW-1:0] work_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign work_prev = dividend;
         assign dvs_prev  = divisor;
         assign pay_prev  = in_payload;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign work_prev = work_ff[k-1];
         assign dvs_prev  = dvs_ff[k-1];
         assign pay_prev  = pay_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      assign trial   = {rem_prev, work_prev[DW-1]};
      assign fits    = (trial >= {1'b0, dvs_prev});
      assign rem_in  = fits ? VW'(trial - {1'b0, dvs_prev}) : trial[VW-1:0];
      assign work_in = {work_prev[DW-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            work_ff[k] <= work_in;
            dvs_ff[k]  <= dvs_prev;
            pay_ff[k]  <= pay_prev;
         end
      end
   end

   assign out_valid   = vld_ff[DW-1];
   assign quotient    = work_ff[DW-1];
   assign out_payload = pay_ff[DW-1];

endmodule

FILE: sv/rwtf_tex_store.sv
// Texel memory for four faces plus the per-face loaded flags.
// Depends on rwtf_pkg for the store control struct.
`timescale 1ns / 1ps

module rwtf_tex_store #(
   parameter int unsigned ADDR_W = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rwtf_pkg::store_ctl_type ctl,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  logic [31:0]            wr_data,
   input  logic [ADDR_W-1:0]      rd_addr,
   output logic [31:0]            rd_data_ff,
   output logic                   hit_ff
);
   import rwtf_pkg::*;

   localparam int unsigned DEPTH = 1 << ADDR_W;

   logic [31:0] mem [DEPTH];
   logic [3:0]  face_loaded_ff;

   always_ff @(posedge clock) begin
      if (ctl.advance && ctl.write) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.advance) begin
         rd_data_ff <= mem[rd_addr];
         hit_ff     <= face_loaded_ff[ctl.read_face];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         face_loaded_ff <= '0;
      end else if (ctl.advance && ctl.write) begin
         face_loaded_ff[ctl.write_face] <= 1'b1;
      end
   end

endmodule

FILE: sv/raycast_wall_texel_fetch.sv
// Throughput: one beat per clock; the divider pipelines and the one-read one-write
// texel memory each take a new beat every cycle, and the whole pipe holds only on output stall.
// Reset: synchronous, active high; clears stage valids, loaded flags and sets both sizes to 64.
// Texel memory is not cleared: an unwritten texel reads as whatever it holds.
`timescale 1ns / 1ps

module raycast_wall_texel_fetch #(
   parameter int unsigned SCREEN_ROWS = 480,
   parameter int unsigned TEX_DIM     = 64
) (
   input  logic         clock,
   input  logic         reset,
   // tdata, lowest bit up: load_face[1:0], load_index[13:2], load_texel[45:14], side[46],
   // dir_x[66:47], dir_y[86:67], player_x[110:87], player_y[134:111],
   // wall_dist[158:135], slice_top[169:159], row[180:170], zero fill to 184.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [183:0] req_tdata,
   // tuser: kind (0 load, 1 shade).
   input  logic         req_tuser,
   // tdata, lowest bit up: color[31:0], face[33:32], zero fill to 40.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import rwtf_pkg::*;

   // Line height numerator is SCREEN_ROWS in Q.16; quotient fits the same width.
   localparam int unsigned NUM_W  = $clog2(SCREEN_ROWS + 1) + 16;
   localparam int unsigned LH_W   = NUM_W;
   localparam int unsigned A_W    = LH_W + 1;
   localparam int unsigned AH_W   = A_W + DIM_W + 1;
   localparam int unsigned FW_W   = $clog2(TEX_DIM * TEX_DIM);
   localparam int unsigned ADDR_W = FW_W + 2;
   localparam int unsigned IW     = $bits(item_type);

   localparam logic [NUM_W-1:0] LH_NUM    = NUM_W'(SCREEN_ROWS) << 16;
   localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(TEX_DIM);
   localparam logic [A_W-1:0]   HALF_ROWS = A_W'(SCREEN_ROWS / 2);
   localparam logic [12:0]      FACE_WORDS = 13'(TEX_DIM * TEX_DIM);

   // The whole pipe moves whenever the output register can take a beat.
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // ---------------------------------------------------------------------
   // Configuration registers. The user writes them only while the pipe is empty; not enforced.
   // ---------------------------------------------------------------------
   logic [DIM_W-1:0] tex_width_ff, tex_height_ff;
   reg_index_type    csr_index;

   assign csr_index  = reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= DIM_RESET;
         tex_height_ff <= DIM_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_index)
            REG_TEX_WIDTH:  tex_width_ff  <= csr_pwdata[DIM_W-1:0];
            REG_TEX_HEIGHT: tex_height_ff <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_TEX_WIDTH:  csr_prdata = 32'(tex_width_ff);
         REG_TEX_HEIGHT: csr_prdata = 32'(tex_height_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Sizes outside one to TEX_DIM are pinned to the nearest end.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > DIM_MAX) r = DIM_MAX;
      else r = v;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stage 0: input register.
   // ---------------------------------------------------------------------
   logic               s0_vld_ff;
   kind_type           s0_kind_ff;
   logic [1:0]         s0_lface_ff;
   logic [11:0]        s0_lidx_ff;
   logic [31:0]        s0_ltex_ff;
   logic               s0_side_ff;
   logic signed [19:0] s0_dx_ff, s0_dy_ff;
   logic [23:0]        s0_px_ff, s0_py_ff, s0_dist_ff;
   logic [10:0]        s0_ds_ff, s0_rw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_kind_ff  <= kind_type'(req_tuser);
         s0_lface_ff <= req_tdata[1:0];
         s0_lidx_ff  <= req_tdata[13:2];
         s0_ltex_ff  <= req_tdata[45:14];
         s0_side_ff  <= req_tdata[46];
         s0_dx_ff    <= req_tdata[66:47];
         s0_dy_ff    <= req_tdata[86:67];
         s0_px_ff    <= req_tdata[110:87];
         s0_py_ff    <= req_tdata[134:111];
         s0_dist_ff  <= req_tdata[158:135];
         s0_ds_ff    <= req_tdata[169:159];
         s0_rw_ff    <= req_tdata[180:170];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: face choice, mirroring and the distance times direction product.
   // A zero direction component counts as not positive.
   // ---------------------------------------------------------------------
   logic               dx_pos, dy_pos;
   logic signed [19:0] s1_dsel;
   logic signed [44:0] s1_prod_in, s1_prod_ff;
   logic [23:0]        s1_base_in, s1_base_ff;
   logic [23:0]        s1_dvs_in, s1_dvs_ff;
   item_type           s1_item_in, s1_item_ff;
   logic               s1_vld_ff;

   assign dx_pos = !s0_dx_ff[19] && (s0_dx_ff != '0);
   assign dy_pos = !s0_dy_ff[19] && (s0_dy_ff != '0);

   always_comb begin
      s1_item_in      = '0;
      s1_item_in.kind = s0_kind_ff;
      s1_item_in.lface = face_type'(s0_lface_ff);
      s1_item_in.lidx = s0_lidx_ff;
      s1_item_in.ltex = s0_ltex_ff;
      s1_item_in.side = s0_side_ff;
      s1_item_in.w    = clamp_dim(tex_width_ff);
      s1_item_in.h    = clamp_dim(tex_height_ff);
      s1_item_in.ds   = s0_ds_ff;
      s1_item_in.rw   = s0_rw_ff;
      if (s0_side_ff) begin
         s1_item_in.face   = dy_pos ? FACE_SOUTH : FACE_NORTH;
         s1_item_in.mirror = s0_dy_ff[19];
         s1_dsel           = s0_dx_ff;
         s1_base_in        = s0_px_ff;
      end else begin
         s1_item_in.face   = dx_pos ? FACE_EAST : FACE_WEST;
         s1_item_in.mirror = dx_pos;
         s1_dsel           = s0_dy_ff;
         s1_base_in        = s0_py_ff;
      end
   end

   assign s1_prod_in = $signed({1'b0, s0_dist_ff}) * s1_dsel;
   // Zero distance divides by one, which gives the saturated height exactly.
   assign s1_dvs_in  = (s0_dist_ff == '0) ? 24'd1 : s0_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_prod_ff <= s1_prod_in;
         s1_base_ff <= s1_base_in;
         s1_dvs_ff  <= s1_dvs_in;
         s1_item_ff <= s1_item_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: fraction of the wall hit in Q0.32 (low word of the exact sum).
   // ---------------------------------------------------------------------
   logic [31:0] s2_frac_in, s2_frac_ff;
   logic [23:0] s2_dvs_ff;
   item_type    s2_item_ff;
   logic        s2_vld_ff;

   assign s2_frac_in = {s1_base_ff[15:0], 16'h0000} + s1_prod_ff[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (en) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_frac_ff <= s2_frac_in;
         s2_dvs_ff  <= s1_dvs_ff;
         s2_item_ff <= s1_item_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: raw texture column. The fraction is below one, so the
   // column is already below the width.
   // ---------------------------------------------------------------------
   logic [DIM_W+31:0] s3_txp;
   item_type          s3_item_in, s3_item_ff;
   logic [23:0]       s3_dvs_ff;
   logic              s3_vld_ff;

   assign s3_txp = (DIM_W + 32)'(s2_frac_ff) * (DIM_W + 32)'(s2_item_ff.w);

   always_comb begin
      s3_item_in    = s2_item_ff;
      s3_item_in.tx = s3_txp[DIM_W+31:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (en) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_item_ff <= s3_item_in;
         s3_dvs_ff  <= s2_dvs_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Line height divider: SCREEN_ROWS in Q.16 over the wall distance.
   // ---------------------------------------------------------------------
   logic             d1_vld;
   logic [NUM_W-1:0] d1_q;
   logic [IW-1:0]    d1_pay;
   item_type         d1_item;

   rwtf_div_pipe #(
      .DW (NUM_W),
      .VW (24),
      .PW (IW)
   ) u_lh_div (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (s3_vld_ff),
      .dividend    (LH_NUM),
      .divisor     (s3_dvs_ff),
      .in_payload  (s3_item_ff),
      .out_valid   (d1_vld),
      .quotient    (d1_q),
      .out_payload (d1_pay)
   );

   assign d1_item = item_type'(d1_pay);

   // ---------------------------------------------------------------------
   // Stage U0: line height floored at one, row offsets, final column.
   // A zero quotient halves to zero just as a height of one does.
   // ---------------------------------------------------------------------
   logic [LH_W-1:0]    u0_lh_in, u0_lh_ff;
   logic signed [A_W-1:0] u0_a_in, u0_a_ff;
   logic signed [11:0] u0_b_in, u0_b_ff;
   item_type           u0_item_in, u0_item_ff;
   logic               u0_vld_ff;

   assign u0_lh_in = (d1_q == '0) ? LH_W'(1) : d1_q;
   assign u0_a_in  = $signed(A_W'(d1_item.ds) - HALF_ROWS + A_W'(d1_q >> 1));
   assign u0_b_in  = $signed(12'(d1_item.rw) - 12'(d1_item.ds));

   always_comb begin
      u0_item_in = d1_item;
      if (d1_item.mirror) begin
         u0_item_in.tx = d1_item.w - d1_item.tx - DIM_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u0_vld_ff <= 1'b0;
      end else if (en) begin
         u0_vld_ff <= d1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u0_lh_ff   <= u0_lh_in;
         u0_a_ff    <= u0_a_in;
         u0_b_ff    <= u0_b_in;
         u0_item_ff <= u0_item_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage U1: scale both offsets by the texture height.
   // ---------------------------------------------------------------------
   logic signed [AH_W-1:0] u1_ah_in, u1_ah_ff, u1_bh_in, u1_bh_ff;
   logic [LH_W-1:0]        u1_lh_ff;
   item_type               u1_item_ff;
   logic                   u1_vld_ff;

   assign u1_ah_in = u0_a_ff * $signed({1'b0, u0_item_ff.h});
   assign u1_bh_in = u0_b_ff * $signed({1'b0, u0_item_ff.h});

   always_ff @(posedge clock) begin
      if (reset) begin
         u1_vld_ff <= 1'b0;
      end else if (en) begin
         u1_vld_ff <= u0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u1_ah_ff   <= u1_ah_in;
         u1_bh_ff   <= u1_bh_in;
         u1_lh_ff   <= u0_lh_ff;
         u1_item_ff <= u0_item_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage U2: split into magnitude and sign so the quotients truncate
   // toward zero.
   // ---------------------------------------------------------------------
   logic [AH_W-1:0] u2_ma_ff, u2_mb_ff;
   logic            u2_na_ff, u2_nb_ff;
   logic [LH_W-1:0] u2_lh_ff;
   item_type        u2_item_ff;
   logic            u2_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         u2_vld_ff <= 1'b0;
      end else if (en) begin
         u2_vld_ff <= u1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u2_na_ff   <= u1_ah_ff[AH_W-1];
         u2_nb_ff   <= u1_bh_ff[AH_W-1];
         u2_ma_ff   <= u1_ah_ff[AH_W-1] ? AH_W'(-u1_ah_ff) : AH_W'(u1_ah_ff);
         u2_mb_ff   <= u1_bh_ff[AH_W-1] ? AH_W'(-u1_bh_ff) : AH_W'(u1_bh_ff);
         u2_lh_ff   <= u1_lh_ff;
         u2_item_ff <= u1_item_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Row dividers, one per offset, running side by side.
   // ---------------------------------------------------------------------
   logic            d2a_vld, d2b_vld;
   logic [AH_W-1:0] d2a_q, d2b_q;
   logic [IW:0]     d2a_pay;
   logic            d2b_pay;
   item_type        d2_item;

   rwtf_div_pipe #(
      .DW (AH_W),
      .VW (LH_W),
      .PW (IW + 1)
   ) u_row_div_a (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (u2_vld_ff),
      .dividend    (u2_ma_ff),
      .divisor     (u2_lh_ff),
      .in_payload  ({u2_item_ff, u2_na_ff}),
      .out_valid   (d2a_vld),
      .quotient    (d2a_q),
      .out_payload (d2a_pay)
   );

   rwtf_div_pipe #(
      .DW (AH_W),
      .VW (LH_W),
      .PW (1)
   ) u_row_div_b (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (u2_vld_ff),
      .dividend    (u2_mb_ff),
      .divisor     (u2_lh_ff),
      .in_payload  (u2_nb_ff),
      .out_valid   (d2b_vld),
      .quotient    (d2b_q),
      .out_payload (d2b_pay)
   );

   assign d2_item = item_type'(d2a_pay[IW:1]);

   // ---------------------------------------------------------------------
   // Stage T0: restore the quotient signs.
   // ---------------------------------------------------------------------
   logic signed [AH_W:0] t0_qa_ff, t0_qb_ff;
   item_type             t0_item_ff;
   logic                 t0_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_vld_ff <= 1'b0;
      end else if (en) begin
         t0_vld_ff <= d2a_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t0_qa_ff   <= d2a_pay[0] ? -$signed({1'b0, d2a_q}) : $signed({1'b0, d2a_q});
         t0_qb_ff   <= d2b_pay ? -$signed({1'b0, d2b_q}) : $signed({1'b0, d2b_q});
         t0_item_ff <= d2_item;
      end
   end

   // ---------------------------------------------------------------------
   // Stage T1: texture row, clamped into the texture.
   // ---------------------------------------------------------------------
   logic signed [AH_W+1:0] t1_sum;
   logic [DIM_W-1:0]       t1_ty_in, t1_ty_ff;
   item_type               t1_item_ff;
   logic                   t1_vld_ff;

   assign t1_sum = (AH_W + 2)'(t0_qa_ff) + (AH_W + 2)'(t0_qb_ff);

   always_comb begin
      if (t1_sum[AH_W+1]) begin
         t1_ty_in = '0;
      end else if (t1_sum >= $signed((AH_W + 2)'(t0_item_ff.h))) begin
         t1_ty_in = t0_item_ff.h - DIM_W'(1);
      end else begin
         t1_ty_in = t1_sum[DIM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_vld_ff <= 1'b0;
      end else if (en) begin
         t1_vld_ff <= t0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ty_ff   <= t1_ty_in;
         t1_item_ff <= t0_item_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage T2: texel index. Row below height and column below width keep
   // the index inside one face.
   // ---------------------------------------------------------------------
   logic [2*DIM_W-1:0] t2_idx_in;
   logic [FW_W-1:0]    t2_idx_ff;
   item_type           t2_item_ff;
   logic               t2_vld_ff;

   assign t2_idx_in = (2 * DIM_W)'(t1_ty_ff) * (2 * DIM_W)'(t1_item_ff.w)
                      + (2 * DIM_W)'(t1_item_ff.tx);

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_vld_ff <= 1'b0;
      end else if (en) begin
         t2_vld_ff <= t1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t2_idx_ff  <= t2_idx_in[FW_W-1:0];
         t2_item_ff <= t1_item_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Texel store. Loads and shades reach it in arrival order, one per
   // cycle unless the output stalls, so a load is seen by every later
   // shade. A load outside the face is dropped and does not mark the face.
   // ---------------------------------------------------------------------
   store_ctl_type     st_ctl;
   logic [ADDR_W-1:0] st_wr_addr, st_rd_addr;
   logic [31:0]       st_rd_data;
   logic              st_hit;

   assign st_ctl.advance    = en;
   assign st_ctl.write      = t2_vld_ff && (t2_item_ff.kind == KIND_LOAD)
                              && ({1'b0, t2_item_ff.lidx} < FACE_WORDS);
   assign st_ctl.write_face = t2_item_ff.lface;
   assign st_ctl.read_face  = t2_item_ff.face;
   assign st_wr_addr = {t2_item_ff.lface, t2_item_ff.lidx[FW_W-1:0]};
   assign st_rd_addr = {t2_item_ff.face, t2_idx_ff};

   rwtf_tex_store #(
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (st_ctl),
      .wr_addr    (st_wr_addr),
      .wr_data    (t2_item_ff.ltex),
      .rd_addr    (st_rd_addr),
      .rd_data_ff (st_rd_data),
      .hit_ff     (st_hit)
   );

   // Stage T3 runs alongside the registered memory read.
   kind_type t3_kind_ff;
   face_type t3_face_ff;
   logic     t3_side_ff;
   logic     t3_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t3_vld_ff <= 1'b0;
      end else if (en) begin
         t3_vld_ff <= t2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t3_kind_ff <= t2_item_ff.kind;
         t3_face_ff <= t2_item_ff.face;
         t3_side_ff <= t2_item_ff.side;
      end
   end

   // ---------------------------------------------------------------------
   // Output register. An unloaded face shows magenta; y-side hits are
   // halved per channel. Load beats leave no result.
   // ---------------------------------------------------------------------
   logic [31:0] color_raw, color_in, rsp_color_ff;
   face_type    rsp_face_ff;
   logic        rsp_vld_ff;

   assign color_raw = st_hit ? st_rd_data : MAGENTA;
   assign color_in  = t3_side_ff ? ((color_raw >> 1) & HALF_MASK) : color_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= t3_vld_ff && (t3_kind_ff == KIND_SHADE);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_color_ff <= color_in;
         rsp_face_ff  <= t3_face_ff;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'b000000, rsp_face_ff, rsp_color_ff};

`ifndef ASSERT_OFF
   // Both row dividers must carry the same beats in lockstep.
   a_row_div_aligned: assert property (@(posedge clock) disable iff (reset)
      d2a_vld == d2b_vld)
      else $error("row dividers out of step");

   // A load beat leaving the memory stage never produces a result.
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (t3_vld_ff && (t3_kind_ff == KIND_LOAD) && en) |=> !rsp_tvalid)
      else $error("load beat produced a result");

   // A shade beat leaving the memory stage always produces a result.
   a_shade_result: assert property (@(posedge clock) disable iff (reset)
      (t3_vld_ff && (t3_kind_ff == KIND_SHADE) && en) |=> rsp_tvalid)
      else $error("shade beat lost");
`endif

endmodule
